// ===== rtl/crc32ww_pkg.sv =====
`default_nettype none

package crc32ww_pkg;

	localparam int BYTES_PER_WORD = 16;
	localparam int CRC_W          = 32;
	localparam int LANE_W         = 64;
	localparam int DATA_W         = 8 * BYTES_PER_WORD;
	localparam int CNT_W          = 5;

	// slave tdata layout, lowest bit up
	localparam int SEED_LSB   = 0;
	localparam int LOW_LSB    = SEED_LSB + CRC_W;
	localparam int HIGH_LSB   = LOW_LSB + LANE_W;
	localparam int CNT_LSB    = HIGH_LSB + LANE_W;
	localparam int S_FIELDS_W = CNT_LSB + CNT_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = CRC_W;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

	typedef logic [CRC_W-1:0] crc_t;

	typedef struct packed {
		logic               start_req;
		crc_t               seed_crc;
		logic [LANE_W-1:0]  data_low;
		logic [LANE_W-1:0]  data_high;
		logic [CNT_W-1:0]   byte_count;
		logic               last;
	} item_t;

	// columns of the register transfer for 0..BYTES_PER_WORD bytes
	typedef logic [BYTES_PER_WORD:0][CRC_W-1:0][CRC_W-1:0] state_mat_t;
	// contribution of each stream bit into a zero register
	typedef logic [DATA_W-1:0][CRC_W-1:0] data_mat_t;

	function automatic crc_t crc_byte(crc_t crc, logic [7:0] b);
		crc_t c;
		c = crc ^ {{(CRC_W-8){1'b0}}, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic state_mat_t build_state_mat();
		state_mat_t m;
		crc_t       c;
		for (int n = 0; n <= BYTES_PER_WORD; n++) begin
			for (int j = 0; j < CRC_W; j++) begin
				c = crc_t'(1) << j;
				for (int p = 0; p < n; p++) begin
					c = crc_byte(c, 8'd0);
				end
				m[n][j] = c;
			end
		end
		return m;
	endfunction

	function automatic data_mat_t build_data_mat();
		data_mat_t  m;
		crc_t       c;
		logic [7:0] b;
		for (int k = 0; k < DATA_W; k++) begin
			c = '0;
			for (int p = 0; p < BYTES_PER_WORD; p++) begin
				b = (p == (k >> 3)) ? (8'd1 << (k & 7)) : 8'd0;
				c = crc_byte(c, b);
			end
			m[k] = c;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/crc32_wide_word_engine.sv =====
// channel  | dir | tdata (lowest bit up)                          | tuser     | tlast
// ---------+-----+------------------------------------------------+-----------+------
// s_       | in  | seed_crc 32, data_low 64, data_high 64,        | start_req | last
//          |     | byte_count 5, zero pad to 168                  |           |
// m_       | out | crc_value 32                                   | -         | -
//
// one item per cycle sustained unless a final word waits on a stalled result; an item
// is held in the input register, and a final word's crc then goes to the result register
// the running crc loop closes through the combinational matrix update
// reset clears both valid flags and presets the running crc to all ones
// a stalled result holds a final word in the input register, and with it
// the slave side, for as long as the stall lasts; other words pass freely
`default_nettype none

module crc32_wide_word_engine (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// seed_crc, data_low, data_high, byte_count, zero pad
	input  wire logic [crc32ww_pkg::S_TDATA_W-1:0]   s_tdata,
	// start_req
	input  wire logic                                s_tuser,
	input  wire logic                                s_tlast,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// crc_value
	output logic [crc32ww_pkg::M_TDATA_W-1:0]        m_tdata
);
	import crc32ww_pkg::*;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// running crc, uninverted
	crc_t running_crc_q;

	// result register
	logic res_valid_q;
	crc_t res_crc_q;

	crc_t crc_base;
	crc_t crc_next;
	logic s1_go;
	logic s_accept;

	// a word that ends a message needs the result slot, any other word only
	// updates the running crc and may leave at once
	assign s1_go    = valid_s1 && (!item_s1.last || !res_valid_q || m_tready);
	assign s_tready = !valid_s1 || s1_go;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1.start_req  <= s_tuser;
			item_s1.seed_crc   <= s_tdata[SEED_LSB +: CRC_W];
			item_s1.data_low   <= s_tdata[LOW_LSB +: LANE_W];
			item_s1.data_high  <= s_tdata[HIGH_LSB +: LANE_W];
			item_s1.byte_count <= s_tdata[CNT_LSB +: CNT_W];
			item_s1.last       <= s_tlast;
		end
	end

	// start loads the inverted seed, otherwise continue the message
	assign crc_base = item_s1.start_req ? ~item_s1.seed_crc : running_crc_q;

	crc32ww_update u_update (
		.crc_in     (crc_base),
		.data       ({item_s1.data_high, item_s1.data_low}),
		.byte_count (item_s1.byte_count),
		.crc_out    (crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '1;
			res_valid_q   <= 1'b0;
		end else begin
			if (s1_go) begin
				running_crc_q <= crc_next;
			end
			if (s1_go && item_s1.last) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.last) begin
			res_crc_q <= ~crc_next;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = res_crc_q;

	// a final word is never dropped while the result slot is still full
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last && res_valid_q && !m_tready |=> valid_s1)
		else $error("final word lost while result stalled");

	// the finished crc is the inverted running register
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && item_s1.last |=> m_tvalid && (m_tdata == ~running_crc_q))
		else $error("result does not match running crc");

	// an empty word that continues a message leaves the register alone
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && !item_s1.start_req && (item_s1.byte_count == '0)
		|=> running_crc_q == $past(running_crc_q))
		else $error("empty word changed running crc");

	// an empty message returns its seed
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && item_s1.start_req && item_s1.last && (item_s1.byte_count == '0)
		|=> m_tdata == $past(item_s1.seed_crc))
		else $error("empty message did not return seed");

endmodule

`default_nettype wire

// ===== rtl/crc32ww_update.sv =====
`default_nettype none

// one word through the crc register as two gf(2) matrix products
module crc32ww_update (
	input  wire crc32ww_pkg::crc_t                           crc_in,
	input  wire logic [crc32ww_pkg::DATA_W-1:0]              data,
	input  wire logic [crc32ww_pkg::CNT_W-1:0]               byte_count,
	output crc32ww_pkg::crc_t                                crc_out
);
	import crc32ww_pkg::*;

	localparam state_mat_t STATE_MAT = build_state_mat();
	localparam data_mat_t  DATA_MAT  = build_data_mat();

	logic [CNT_W-1:0]  nbytes;
	logic [CNT_W-1:0]  pad_bytes;
	logic [DATA_W-1:0] masked;
	logic [DATA_W-1:0] aligned;
	crc_t              state_part;
	crc_t              data_part;

	assign nbytes    = (byte_count > CNT_W'(BYTES_PER_WORD)) ? CNT_W'(BYTES_PER_WORD)
	                                                         : byte_count;
	assign pad_bytes = CNT_W'(BYTES_PER_WORD) - nbytes;

	// drop bytes past the count, then push them to the end of the word so
	// leading zero bytes into a zero register change nothing
	always_comb begin
		for (int b = 0; b < BYTES_PER_WORD; b++) begin
			masked[b*8 +: 8] = (CNT_W'(b) < nbytes) ? data[b*8 +: 8] : 8'd0;
		end
		aligned = masked << {pad_bytes, 3'b000};
	end

	always_comb begin
		state_part = '0;
		for (int j = 0; j < CRC_W; j++) begin
			state_part = state_part ^ (crc_in[j] ? STATE_MAT[nbytes][j] : '0);
		end
	end

	always_comb begin
		data_part = '0;
		for (int k = 0; k < DATA_W; k++) begin
			data_part = data_part ^ (aligned[k] ? DATA_MAT[k] : '0);
		end
	end

	assign crc_out = state_part ^ data_part;

endmodule

`default_nettype wire
